// File: sv/neighbour_list_cutoff_filter_macros.svh
// ----------------------------------------------------------------------------
// Neighbour list cutoff filter assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_LIST_CUTOFF_FILTER_MACROS_SVH
`define NEIGHBOUR_LIST_CUTOFF_FILTER_MACROS_SVH

// checked outside reset only
`define NLCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// also checked while reset is high
`define NLCF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/nlcf_pkg.sv
// ----------------------------------------------------------------------------
// nlcf_pkg
// Types and constants shared by the neighbour list cutoff filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nlcf_pkg;

  localparam int COORD_BITS      = 24;
  localparam int INDEX_BITS      = 16;
  localparam int DIST_BITS       = 48;
  localparam int SQ_BITS         = 2 * COORD_BITS;
  localparam int SUM_BITS        = SQ_BITS + 2;
  localparam int CFG_DATA_BITS   = 48;
  localparam int SLOT_BITS       = 10;
  localparam int LENGTH_BITS     = 11;
  localparam int MAX_NEIGHBOURS_DEF = 1024;
  localparam int QUEUE_DEPTH     = 8;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COORD_BITS-1:0] BOX_RESET  = '1;
  localparam logic [DIST_BITS-1:0]  DIST_MAX   = '1;

  typedef enum logic [0:0] {
    REG_BOX    = 1'b0,
    REG_CUTOFF = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  accepted;
    logic [INDEX_BITS-1:0] index;
    logic [DIST_BITS-1:0]  dist_sq;
    logic                  last;
  } class_item_t;

  typedef struct packed {
    logic                empty;
    logic [QUEUE_CW-1:0] count;
  } queue_status_t;

endpackage

`default_nettype wire

// File: sv/nlcf_front.sv
// ----------------------------------------------------------------------------
// nlcf_front
// Takes items in, forms minimum-image squared distance and classifies them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nlcf_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [0:0]                           cfg_index,
  input  wire logic [nlcf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [nlcf_pkg::INDEX_BITS-1:0]      ref_index,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      ref_x,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      ref_y,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      ref_z,
  input  wire logic [nlcf_pkg::INDEX_BITS-1:0]      cand_index,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      cand_x,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      cand_y,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      cand_z,
  input  wire logic                                 last_candidate,
  input  wire nlcf_pkg::queue_status_t              q_status,
  output logic                                      push,
  output nlcf_pkg::class_item_t                     push_item
);

  localparam int CB = nlcf_pkg::COORD_BITS;
  localparam int IB = nlcf_pkg::INDEX_BITS;
  localparam int SQ = nlcf_pkg::SQ_BITS;
  localparam int SB = nlcf_pkg::SUM_BITS;
  localparam int DB = nlcf_pkg::DIST_BITS;
  localparam int OW = nlcf_pkg::QUEUE_CW + 1;

  logic [CB-1:0] box_edge;
  logic [DB-1:0] cut_limit;

  logic          v1, v2, v3, v4, v5;
  logic [IB-1:0] idx1, idx2, idx3, idx4, idx5;
  logic [IB-1:0] ref1;
  logic          last1, last2, last3, last4, last5;
  logic          ne2, ne3, ne4, ne5;
  logic [CB-1:0] a1 [3];
  logic [CB-1:0] b1 [3];
  logic [CB-1:0] d2 [3];
  logic [CB-1:0] f3 [3];
  logic [SQ-1:0] sq4 [3];
  logic [SB-1:0] sum5;
  logic [DB-1:0] dist_sat;
  logic [OW-1:0] occupancy;
  logic          take;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_edge  <= nlcf_pkg::BOX_RESET;
      cut_limit <= '0;
    end else if (cfg_we) begin
      case (nlcf_pkg::cfg_reg_t'(cfg_index))
        nlcf_pkg::REG_BOX:    box_edge  <= cfg_data[CB-1:0];
        nlcf_pkg::REG_CUTOFF: cut_limit <= cfg_data[DB-1:0];
        default: ;
      endcase
    end
  end

  // Queue room is reserved for every item in flight.
  assign occupancy = OW'(q_status.count) + OW'(v1) + OW'(v2) + OW'(v3) + OW'(v4)
                   + OW'(v5);
  assign in_stall  = occupancy >= OW'(nlcf_pkg::QUEUE_DEPTH);
  assign take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    idx1  <= cand_index;
    ref1  <= ref_index;
    last1 <= last_candidate;
    a1[0] <= cand_x;
    a1[1] <= cand_y;
    a1[2] <= cand_z;
    b1[0] <= ref_x;
    b1[1] <= ref_y;
    b1[2] <= ref_z;

    idx2  <= idx1;
    last2 <= last1;
    ne2   <= idx1 != ref1;
    for (int i = 0; i < 3; i++) begin
      d2[i] <= (a1[i] >= b1[i]) ? a1[i] - b1[i] : b1[i] - a1[i];
    end

    idx3  <= idx2;
    last3 <= last2;
    ne3   <= ne2;
    for (int i = 0; i < 3; i++) begin
      if ({d2[i], 1'b0} > {1'b0, box_edge}) begin
        f3[i] <= (d2[i] >= box_edge) ? d2[i] - box_edge : box_edge - d2[i];
      end else begin
        f3[i] <= d2[i];
      end
    end

    idx4  <= idx3;
    last4 <= last3;
    ne4   <= ne3;
    for (int i = 0; i < 3; i++) begin
      sq4[i] <= SQ'(f3[i]) * SQ'(f3[i]);
    end

    idx5  <= idx4;
    last5 <= last4;
    ne5   <= ne4;
    sum5  <= SB'(sq4[0]) + SB'(sq4[1]) + SB'(sq4[2]);
  end

  assign dist_sat = (sum5 > SB'(nlcf_pkg::DIST_MAX)) ? nlcf_pkg::DIST_MAX : sum5[DB-1:0];

  always_comb begin
    push               = v5;
    push_item.accepted = (dist_sat < cut_limit) && ne5;
    push_item.index    = idx5;
    push_item.dist_sq  = dist_sat;
    push_item.last     = last5;
  end

endmodule

`default_nettype wire

// File: sv/nlcf_fifo.sv
// ----------------------------------------------------------------------------
// nlcf_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nlcf_fifo (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire nlcf_pkg::class_item_t    push_item,
  input  wire logic                     pop,
  output nlcf_pkg::class_item_t         head,
  output nlcf_pkg::queue_status_t       q_status
);

  localparam int AW = nlcf_pkg::QUEUE_AW;
  localparam int CW = nlcf_pkg::QUEUE_CW;

  nlcf_pkg::class_item_t mem [nlcf_pkg::QUEUE_DEPTH];
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         rd_ptr;
  logic [CW-1:0]         count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(nlcf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(nlcf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head           = mem[rd_ptr];
  assign q_status.empty = count == '0;
  assign q_status.count = count;

endmodule

`default_nettype wire

// File: sv/nlcf_back.sv
// ----------------------------------------------------------------------------
// nlcf_back
// Assigns list slots, keeps the list count and holds the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nlcf_back #(
  parameter int MAX_NEIGHBOURS = nlcf_pkg::MAX_NEIGHBOURS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire nlcf_pkg::class_item_t                head,
  input  wire nlcf_pkg::queue_status_t              q_status,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      accepted,
  output logic [nlcf_pkg::INDEX_BITS-1:0]           neighbour_index,
  output logic [nlcf_pkg::SLOT_BITS-1:0]            list_slot,
  output logic [nlcf_pkg::DIST_BITS-1:0]            dist_sq,
  output logic [nlcf_pkg::LENGTH_BITS-1:0]          list_length,
  output logic                                      list_done,
  output logic                                      overflow
);

  localparam int CW = $clog2(MAX_NEIGHBOURS + 1);

  logic [CW-1:0] accepted_count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] len_next;
  logic          room;
  logic          store;

  assign pop   = !q_status.empty && (!out_valid || !out_stall);
  assign room  = accepted_count < CW'(MAX_NEIGHBOURS);
  assign store = head.accepted && room;

  always_comb begin
    len_next   = store ? accepted_count + 1'b1 : accepted_count;
    count_next = head.last ? '0 : len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        accepted_count <= count_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      accepted        <= head.accepted;
      neighbour_index <= head.index;
      list_slot       <= store ? nlcf_pkg::SLOT_BITS'(accepted_count) : '0;
      dist_sq         <= head.dist_sq;
      list_length     <= nlcf_pkg::LENGTH_BITS'(len_next);
      list_done       <= head.last;
      overflow        <= head.accepted && !room;
    end
  end

endmodule

`default_nettype wire

// File: sv/neighbour_list_cutoff_filter.sv
// One item per clock unless in_stall: each pairs a reference particle with a
// candidate and yields one result, through five front stages, one queue write
// and one output register. The front accepts a new item every cycle while the
// 8-entry queue has room for everything in flight; in_stall rises only when
// output-side stalls fill it. The user must issue configuration writes only
// while the block holds no item; the block itself does not enforce this.
// ----------------------------------------------------------------------------
// neighbour_list_cutoff_filter
// Minimum-image cutoff test and slot assignment for Verlet neighbour lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module neighbour_list_cutoff_filter #(
  parameter int MAX_NEIGHBOURS = nlcf_pkg::MAX_NEIGHBOURS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [0:0]                           cfg_index,
  input  wire logic [nlcf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [nlcf_pkg::INDEX_BITS-1:0]      ref_index,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      ref_x,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      ref_y,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      ref_z,
  input  wire logic [nlcf_pkg::INDEX_BITS-1:0]      cand_index,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      cand_x,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      cand_y,
  input  wire logic [nlcf_pkg::COORD_BITS-1:0]      cand_z,
  input  wire logic                                 last_candidate,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      accepted,
  output logic [nlcf_pkg::INDEX_BITS-1:0]           neighbour_index,
  output logic [nlcf_pkg::SLOT_BITS-1:0]            list_slot,
  output logic [nlcf_pkg::DIST_BITS-1:0]            dist_sq,
  output logic [nlcf_pkg::LENGTH_BITS-1:0]          list_length,
  output logic                                      list_done,
  output logic                                      overflow
);

  logic                    push;
  logic                    pop;
  nlcf_pkg::class_item_t   push_item;
  nlcf_pkg::class_item_t   head;
  nlcf_pkg::queue_status_t q_status;

  nlcf_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .ref_index      (ref_index),
    .ref_x          (ref_x),
    .ref_y          (ref_y),
    .ref_z          (ref_z),
    .cand_index     (cand_index),
    .cand_x         (cand_x),
    .cand_y         (cand_y),
    .cand_z         (cand_z),
    .last_candidate (last_candidate),
    .q_status       (q_status),
    .push           (push),
    .push_item      (push_item)
  );

  nlcf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  nlcf_back #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .q_status        (q_status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .accepted        (accepted),
    .neighbour_index (neighbour_index),
    .list_slot       (list_slot),
    .dist_sq         (dist_sq),
    .list_length     (list_length),
    .list_done       (list_done),
    .overflow        (overflow)
  );

endmodule

`default_nettype wire

// File: sv/nlcf_checker.sv
// ----------------------------------------------------------------------------
// nlcf_checker
// Port-level checks on results of the neighbour list cutoff filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "neighbour_list_cutoff_filter_macros.svh"

module nlcf_checker #(
  parameter int MAX_NEIGHBOURS = nlcf_pkg::MAX_NEIGHBOURS_DEF
) (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 out_valid,
  input wire logic                                 out_stall,
  input wire logic                                 accepted,
  input wire logic [nlcf_pkg::SLOT_BITS-1:0]       list_slot,
  input wire logic [nlcf_pkg::DIST_BITS-1:0]       dist_sq,
  input wire logic [nlcf_pkg::LENGTH_BITS-1:0]     list_length,
  input wire logic                                 overflow
);

  `NLCF_ASSERT_RST(a_rst_quiet, rst |=> !out_valid, "result shown right after reset")
  `NLCF_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(dist_sq), "stalled result changed")
  `NLCF_ASSERT(a_ovf_acc, out_valid && overflow |-> accepted, "overflow on a rejected item")
  `NLCF_ASSERT(a_rej_slot, out_valid && !accepted |-> list_slot == '0, "slot given to a rejected item")
  `NLCF_ASSERT(a_len_cap, out_valid |-> 32'(list_length) <= MAX_NEIGHBOURS, "list length past capacity")

endmodule

bind neighbour_list_cutoff_filter nlcf_checker #(
  .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
) u_nlcf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .accepted    (accepted),
  .list_slot   (list_slot),
  .dist_sq     (dist_sq),
  .list_length (list_length),
  .overflow    (overflow)
);

`default_nettype wire

// File: bench/neighbour_list_cutoff_filter_test.sv
// ----------------------------------------------------------------------------
// neighbour_list_cutoff_filter_test
// Drives reference/candidate pairs through the cutoff filter, with random
// gaps on the input and random stalls on the output. A local minimum-image
// distance and slot-count predictor works out each result, and every
// result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module neighbour_list_cutoff_filter_test;
  import nlcf_pkg::*;

  localparam int unsigned PIPE_LATENCY = 7;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned Q            = 4096;
  localparam int unsigned LIST_CAP     = MAX_NEIGHBOURS_DEF;
  localparam int unsigned LONG_LIST    = 120;

  typedef struct packed {
    logic [INDEX_BITS-1:0] ref_idx;
    logic [COORD_BITS-1:0] rx, ry, rz;
    logic [INDEX_BITS-1:0] cand_idx;
    logic [COORD_BITS-1:0] cx, cy, cz;
    logic                  last;
  } pair_t;

  typedef struct packed {
    logic                   accepted;
    logic [INDEX_BITS-1:0]  index;
    logic [SLOT_BITS-1:0]   slot;
    logic [DIST_BITS-1:0]   sq_dist;
    logic [LENGTH_BITS-1:0] length;
    logic                   done;
    logic                   ovf;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [INDEX_BITS-1:0] ref_index, cand_index;
  logic [COORD_BITS-1:0] ref_x, ref_y, ref_z, cand_x, cand_y, cand_z;
  logic last_candidate;
  logic out_valid;
  logic out_stall;
  logic accepted;
  logic [INDEX_BITS-1:0] neighbour_index;
  logic [SLOT_BITS-1:0] list_slot;
  logic [DIST_BITS-1:0] dist_sq;
  logic [LENGTH_BITS-1:0] list_length;
  logic list_done;
  logic overflow;

  // predictor state
  logic [COORD_BITS-1:0]  box_edge = BOX_RESET;
  logic [DIST_BITS-1:0]   cut_sq = '0;
  logic [LENGTH_BITS-1:0] list_count = '0;

  verdict_t awaited[$];
  verdict_t got_v, want_v;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  int unsigned stall_roll;
  logic idle_on = 1'b1;

  neighbour_list_cutoff_filter dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .ref_index      (ref_index),
    .ref_x          (ref_x),
    .ref_y          (ref_y),
    .ref_z          (ref_z),
    .cand_index     (cand_index),
    .cand_x         (cand_x),
    .cand_y         (cand_y),
    .cand_z         (cand_z),
    .last_candidate (last_candidate),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .accepted       (accepted),
    .neighbour_index(neighbour_index),
    .list_slot      (list_slot),
    .dist_sq        (dist_sq),
    .list_length    (list_length),
    .list_done      (list_done),
    .overflow       (overflow)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still awaited", $time, awaited.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // output back-pressure: mostly short stalls, a few long ones
  always @(negedge clk) begin
    if (rst || !idle_on) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 12) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (stall_roll < 14) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(10, 40);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic [COORD_BITS-1:0] crd(input int unsigned v);
    return COORD_BITS'(v);
  endfunction

  function automatic logic [COORD_BITS-1:0] min_image(input logic [COORD_BITS-1:0] a, b,
                                                      input logic [COORD_BITS-1:0] box);
    logic [COORD_BITS-1:0] d;
    d = (a >= b) ? a - b : b - a;
    if ({d, 1'b0} > {1'b0, box})
      d = (d >= box) ? d - box : box - d;
    return d;
  endfunction

  function automatic verdict_t judge_pair(input pair_t p);
    logic [COORD_BITS-1:0] dx, dy, dz;
    logic [SUM_BITS-1:0] total;
    verdict_t v;
    dx = min_image(p.cx, p.rx, box_edge);
    dy = min_image(p.cy, p.ry, box_edge);
    dz = min_image(p.cz, p.rz, box_edge);
    total = SUM_BITS'(dx) * SUM_BITS'(dx) + SUM_BITS'(dy) * SUM_BITS'(dy)
          + SUM_BITS'(dz) * SUM_BITS'(dz);
    v.sq_dist = (total > {2'b00, DIST_MAX}) ? DIST_MAX : total[DIST_BITS-1:0];
    v.accepted = (v.sq_dist < cut_sq) && (p.cand_idx != p.ref_idx);
    v.index = p.cand_idx;
    v.slot = '0;
    v.ovf = 1'b0;
    if (v.accepted) begin
      if (32'(list_count) < LIST_CAP) begin
        v.slot = list_count[SLOT_BITS-1:0];
        list_count++;
      end else begin
        v.ovf = 1'b1;
      end
    end
    v.length = list_count;
    v.done = p.last;
    if (p.last)
      list_count = '0;
    return v;
  endfunction

  task automatic report_field(input string name, input logic [DIST_BITS-1:0] want,
                              input logic [DIST_BITS-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic compare_verdict(input verdict_t want, input verdict_t got);
    report_field("accepted", DIST_BITS'(want.accepted), DIST_BITS'(got.accepted));
    report_field("neighbour_index", DIST_BITS'(want.index), DIST_BITS'(got.index));
    report_field("list_slot", DIST_BITS'(want.slot), DIST_BITS'(got.slot));
    report_field("dist_sq", want.sq_dist, got.sq_dist);
    report_field("list_length", DIST_BITS'(want.length), DIST_BITS'(got.length));
    report_field("list_done", DIST_BITS'(want.done), DIST_BITS'(got.done));
    report_field("overflow", DIST_BITS'(want.ovf), DIST_BITS'(got.ovf));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_v = {accepted, neighbour_index, list_slot, dist_sq, list_length, list_done, overflow};
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual index 0x%0h",
                 $time, neighbour_index);
      end else begin
        want_v = awaited.pop_front();
        compare_verdict(want_v, got_v);
      end
    end
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (!idle_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 96)
      return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic pair_t mk_pair(input logic [INDEX_BITS-1:0] ri,
                                    input logic [COORD_BITS-1:0] rx, ry, rz,
                                    input logic [INDEX_BITS-1:0] ci,
                                    input logic [COORD_BITS-1:0] cx, cy, cz,
                                    input logic last);
    pair_t p;
    p.ref_idx = ri;
    p.rx = rx;
    p.ry = ry;
    p.rz = rz;
    p.cand_idx = ci;
    p.cx = cx;
    p.cy = cy;
    p.cz = cz;
    p.last = last;
    return p;
  endfunction

  task automatic send_pair(input pair_t p);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    ref_index = p.ref_idx;
    ref_x = p.rx;
    ref_y = p.ry;
    ref_z = p.rz;
    cand_index = p.cand_idx;
    cand_x = p.cx;
    cand_y = p.cy;
    cand_z = p.cz;
    last_candidate = p.last;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited.insert(awaited.size(), judge_pair(p));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = which;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (which == REG_BOX)
      box_edge = value[COORD_BITS-1:0];
    else
      cut_sq = value[DIST_BITS-1:0];
  endtask

  function automatic logic [COORD_BITS-1:0] coord_in_box(input logic [COORD_BITS-1:0] box);
    if (box == 0 || $urandom_range(0, 9) == 0)
      return crd($urandom);
    return crd($urandom_range(0, 32'(box) - 1));
  endfunction

  // random point within half a box of c on one axis, wrapped into the box
  function automatic logic [COORD_BITS-1:0] near_coord(input logic [COORD_BITS-1:0] c,
                                                       input logic [COORD_BITS-1:0] box);
    longint span, v;
    span = (box == 0) ? longint'(BOX_RESET) : longint'(box);
    v = longint'(c) + longint'($urandom_range(0, 32'(span))) - span / 2;
    v = v % span;
    if (v < 0)
      v += span;
    return v[COORD_BITS-1:0];
  endfunction

  // reset values: box at full range, cutoff zero so nothing is accepted
  task automatic test_reset_values();
    send_pair(mk_pair(16'd0, 0, 0, 0, 16'd1, 0, 0, 0, 1'b0));
    send_pair(mk_pair(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 0, 0, 0, 1'b0));
    send_pair(mk_pair(16'd3, 0, 0, 0, 16'd4, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1));
    wait_idle();
  endtask

  task automatic test_directed_cases();
    write_reg(REG_BOX, CFG_DATA_BITS'(10 * Q));
    write_reg(REG_CUTOFF, 48'd9 << 24);
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q),
                      16'd101, crd(2 * Q), crd(2 * Q), crd(2 * Q), 1'b0));
    // self pair at zero distance
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q), 16'd100, crd(Q), crd(Q), crd(Q), 1'b0));
    // exactly on the cutoff, then one step inside it
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q),
                      16'd102, crd(4 * Q), crd(Q), crd(Q), 1'b0));
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q),
                      16'd103, crd(4 * Q - 1), crd(Q), crd(Q), 1'b0));
    // periodic wrap and exact half box
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q),
                      16'd104, crd(9 * Q + Q / 2), crd(Q), crd(Q), 1'b0));
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q),
                      16'd105, crd(6 * Q), crd(Q), crd(Q), 1'b0));
    // candidates outside the box, single fold only
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q),
                      16'd106, crd(26 * Q), crd(Q), crd(Q), 1'b0));
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q),
                      16'd107, crd(11 * Q), crd(Q), crd(Q), 1'b0));
    send_pair(mk_pair(16'd100, crd(Q), crd(Q), crd(Q), 16'hFFFF, crd(Q), crd(Q), crd(Q), 1'b1));
    send_pair(mk_pair(16'd0, 0, 0, 0, 16'hFFFF, crd(Q / 2), 0, 0, 1'b0));
    send_pair(mk_pair(16'd0, 0, 0, 0, 16'd0, 0, 0, 0, 1'b1));
    send_pair(mk_pair(16'd5, crd(99 * Q / 10), crd(99 * Q / 10), crd(99 * Q / 10),
                      16'd6, crd(Q / 10), crd(Q / 10), crd(Q / 10), 1'b0));
    send_pair(mk_pair(16'd5, 0, 0, 0, 16'd7, crd(5 * Q), crd(5 * Q), crd(5 * Q), 1'b1));
    wait_idle();
  endtask

  task automatic test_box_extremes();
    write_reg(REG_BOX, 48'd1);
    write_reg(REG_CUTOFF, {CFG_DATA_BITS{1'b1}});
    send_pair(mk_pair(16'd1, 0, 0, 0, 16'd2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    send_pair(mk_pair(16'd1, 0, 0, 0, 16'd3, 1, 1, 1, 1'b0));
    send_pair(mk_pair(16'd1, 0, 0, 0, 16'd4, 24'hFFFFFF, 0, 0, 1'b1));
    wait_idle();
    // zero box: no fold at all
    write_reg(REG_BOX, 48'd0);
    send_pair(mk_pair(16'd9, 0, 0, 0, 16'd8, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    send_pair(mk_pair(16'd9, 24'hFFFFFF, 0, 0, 16'd8, 24'hFFFFFA, 0, 0, 1'b1));
    wait_idle();
    write_reg(REG_BOX, {24'd0, BOX_RESET});
    write_reg(REG_CUTOFF, 48'hC000_0000_0000);
    send_pair(mk_pair(16'd9, 0, 0, 0, 16'd8, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1));
    wait_idle();
  endtask

  // one long list in which nearly every candidate takes a slot
  task automatic test_long_list();
    logic [INDEX_BITS-1:0] ri, ci;
    int unsigned k;
    write_reg(REG_BOX, {24'd0, BOX_RESET});
    write_reg(REG_CUTOFF, {CFG_DATA_BITS{1'b1}});
    ri = INDEX_BITS'($urandom);
    for (k = 0; k < LONG_LIST; k++) begin
      ci = INDEX_BITS'($urandom);
      if (ci == ri)
        ci = ci ^ 16'd1;
      send_pair(mk_pair(ri, crd($urandom), crd($urandom), crd($urandom),
                        ci, crd($urandom), crd($urandom), crd($urandom),
                        k == LONG_LIST - 1));
    end
    for (k = 0; k < 3; k++)
      send_pair(mk_pair(ri, 0, 0, 0, ri + 16'd1, crd(k), 0, 0, k == 2));
    wait_idle();
  endtask

  task automatic run_lists(input int unsigned target);
    int unsigned sent, len, k, roll;
    logic [INDEX_BITS-1:0] ri;
    logic [COORD_BITS-1:0] rx, ry, rz;
    pair_t p;
    sent = 0;
    while (sent < target) begin
      ri = INDEX_BITS'($urandom);
      rx = coord_in_box(box_edge);
      ry = coord_in_box(box_edge);
      rz = coord_in_box(box_edge);
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        p = mk_pair(ri, rx, ry, rz, INDEX_BITS'($urandom), near_coord(rx, box_edge),
                    near_coord(ry, box_edge), near_coord(rz, box_edge), k == len - 1);
        if (roll < 8) begin
          p.cand_idx = ri;
        end else if (roll < 20) begin
          p.cx = crd($urandom);
          p.cy = crd($urandom);
          p.cz = crd($urandom);
          p.last = p.last | ($urandom_range(0, 7) == 0);
        end
        send_pair(p);
        sent++;
      end
    end
  endtask

  task automatic test_random_lists();
    int unsigned ph;
    logic [COORD_BITS-1:0] box;
    logic [DIST_BITS-1:0] radius, cut;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: box = BOX_RESET;
        1: box = crd($urandom_range(1, 32'hFF_FFFF));
        2: box = crd($urandom_range(1, 4096));
        3: box = crd(10 * Q);
        default: box = BOX_RESET;
      endcase
      radius = (ph == 4) ? DIST_BITS'(box / 4) :
               (ph == 2) ? DIST_BITS'(box / 3) : DIST_BITS'(box / 2);
      cut = radius * radius;
      if (ph == 3)
        cut = DIST_BITS'({$urandom, $urandom} >> $urandom_range(0, 24));
      write_reg(REG_BOX, {24'd0, box});
      write_reg(REG_CUTOFF, cut);
      idle_on = (ph != 1);
      run_lists(65);
      wait_idle();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BOX;
    cfg_data = '0;
    in_valid = 1'b0;
    ref_index = '0;
    ref_x = '0;
    ref_y = '0;
    ref_z = '0;
    cand_index = '0;
    cand_x = '0;
    cand_y = '0;
    cand_z = '0;
    last_candidate = 1'b0;
    out_stall = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_directed_cases();
    test_box_extremes();
    test_long_list();
    test_random_lists();

    wait_idle();
    repeat (PIPE_LATENCY + 3) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
